// ===== design/tksk_pkg.sv =====
package tksk_pkg;

    localparam int SCORE_W    = 16;
    localparam int ENTRY_W    = 20;
    localparam int OPC_W      = 2;
    localparam int RANK_W     = 4;
    localparam int CNT_W      = 5;
    localparam int KEEP_W     = 5;
    localparam int KEEP_RESET = 16;
    localparam int SLOTS_DEF  = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_OFFER = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ENTRY_W-1:0] entry;
    } t_slot;

endpackage

// ===== design/tksk_cell.sv =====
// One rank of the sorted list. On an offer that reaches this cell it takes
// either the new candidate (insertion point) or the word of the cell above.
module tksk_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_offer,
    input  logic                  i_reach,
    input  logic                  i_reach_up,
    input  tksk_pkg::t_slot       i_up,
    input  tksk_pkg::t_slot       i_new,
    output tksk_pkg::t_slot       o_slot,
    output logic                  o_gt
);

    tksk_pkg::t_slot r_slot;
    tksk_pkg::t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_clear) begin
            // entry ids survive a clear
            n_slot.score = '0;
        end else if (i_offer && i_reach) begin
            n_slot = i_reach_up ? i_up : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_gt   = i_new.score > r_slot.score;

endmodule

// ===== design/top_k_score_keeper.sv =====
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_stall    i_opcode, i_score, i_entry_id
// out       output     o_out_valid / i_out_stall  o_rank, o_kept_score, o_kept_entry,
//                                                 o_no_hit, o_last
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_keep_count
//
// Clear and offer do not stall the input; on an offer all cells compare against
// the new score in parallel and the list shifts by one below the insertion point.
// A readout holds the input stalled until the single output register has loaded
// every emitted word (1..keep count); it loads one slot per cycle, but not while
// its word waits on i_out_stall. Only the last readout word, while it waits on
// i_out_stall, does not stop later clears or offers.
// Reset (synchronous, active low) zeroes all slots and the offer count and sets
// the keep count to 16 (or SLOTS if smaller).
module top_k_score_keeper #(
    parameter int SLOTS = tksk_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tksk_pkg::OPC_W-1:0]    i_opcode,
    input  logic [tksk_pkg::SCORE_W-1:0]  i_score,
    input  logic [tksk_pkg::ENTRY_W-1:0]  i_entry_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tksk_pkg::RANK_W-1:0]   o_rank,
    output logic [tksk_pkg::SCORE_W-1:0]  o_kept_score,
    output logic [tksk_pkg::ENTRY_W-1:0]  o_kept_entry,
    output logic                          o_no_hit,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tksk_pkg::KEEP_W-1:0]   i_cfg_keep_count
);

    localparam int KW       = $clog2(SLOTS + 1);
    localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEEP_RST = (tksk_pkg::KEEP_RESET > SLOTS) ? SLOTS : tksk_pkg::KEEP_RESET;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [KW-1:0]                r_keep, n_keep;
    logic [tksk_pkg::CNT_W-1:0]   r_offered, n_offered;
    logic [KW-1:0]                r_rd_n, n_rd_n;
    logic [IW-1:0]                r_idx, n_idx;
    logic                         r_rd_nohit, n_rd_nohit;
    logic                         r_out_valid, n_out_valid;
    logic [tksk_pkg::RANK_W-1:0]  r_rank, n_rank;
    tksk_pkg::t_slot              r_out, n_out;
    logic                         r_no_hit, n_no_hit;
    logic                         r_last, n_last;

    logic                         w_in_acc;
    logic                         w_clear;
    logic                         w_offer;
    logic                         w_load_out;
    logic                         w_rd_last;
    logic [SLOTS-1:0]             w_win;
    logic [SLOTS-1:0]             w_gt;
    logic [SLOTS-1:0]             w_block;
    logic [SLOTS-1:0]             w_reach;
    tksk_pkg::t_slot              w_new;
    tksk_pkg::t_slot              w_slot [SLOTS];

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_clear  = w_in_acc && (i_opcode == tksk_pkg::OP_CLEAR);
    assign w_offer  = w_in_acc && (i_opcode == tksk_pkg::OP_OFFER);
    assign w_new    = '{score: i_score, entry: i_entry_id};

    // a window slot blocks the bubble unless the new score beats it
    assign w_block = w_win & ~w_gt;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            localparam logic [SLOTS-1:0] UP_MASK = {SLOTS{1'b1}} << gi;

            assign w_win[gi]   = 32'(r_keep) > gi;
            assign w_reach[gi] = w_win[gi] && !(|(w_block & UP_MASK));

            if (gi == 0) begin : g_top
                tksk_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_clear    (w_clear),
                    .i_offer    (w_offer),
                    .i_reach    (w_reach[gi]),
                    .i_reach_up (1'b0),
                    .i_up       (w_new),
                    .i_new      (w_new),
                    .o_slot     (w_slot[gi]),
                    .o_gt       (w_gt[gi])
                );
            end else begin : g_rest
                tksk_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_clear    (w_clear),
                    .i_offer    (w_offer),
                    .i_reach    (w_reach[gi]),
                    .i_reach_up (w_reach[gi-1]),
                    .i_up       (w_slot[gi-1]),
                    .i_new      (w_new),
                    .o_slot     (w_slot[gi]),
                    .o_gt       (w_gt[gi])
                );
            end
        end
    endgenerate

    assign w_load_out = (r_state == S_READ) && (!r_out_valid || !i_out_stall);
    assign w_rd_last  = r_rd_nohit || ((32'(r_idx) + 1) == 32'(r_rd_n));

    always_comb begin
        n_state     = r_state;
        n_keep      = r_keep;
        n_offered   = r_offered;
        n_rd_n      = r_rd_n;
        n_idx       = r_idx;
        n_rd_nohit  = r_rd_nohit;
        n_out_valid = r_out_valid;
        n_rank      = r_rank;
        n_out       = r_out;
        n_no_hit    = r_no_hit;
        n_last      = r_last;

        if (i_cfg_valid) begin
            if (i_cfg_keep_count == '0) begin
                n_keep = KW'(1);
            end else if (32'(i_cfg_keep_count) > SLOTS) begin
                n_keep = KW'(SLOTS);
            end else begin
                n_keep = KW'(i_cfg_keep_count);
            end
        end

        if (w_in_acc) begin
            case (i_opcode)
                tksk_pkg::OP_CLEAR: begin
                    n_offered = '0;
                end
                tksk_pkg::OP_OFFER: begin
                    if (r_offered != tksk_pkg::CNT_MAX) begin
                        n_offered = r_offered + 1'b1;
                    end
                end
                tksk_pkg::OP_READ: begin
                    n_state    = S_READ;
                    n_idx      = '0;
                    n_rd_nohit = (r_offered == '0);
                    n_rd_n     = (32'(r_offered) < 32'(r_keep)) ? KW'(r_offered) : r_keep;
                end
                default: begin
                end
            endcase
        end

        if (o_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_rank      = tksk_pkg::RANK_W'(r_idx);
            n_no_hit    = r_rd_nohit;
            n_last      = w_rd_last;
            n_out       = r_rd_nohit ? '0 : w_slot[r_idx];
            if (w_rd_last) begin
                n_state = S_IDLE;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_keep      <= KW'(KEEP_RST);
            r_offered   <= '0;
            r_out_valid <= 1'b0;
            r_rd_n      <= '0;
            r_idx       <= '0;
            r_rd_nohit  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keep      <= n_keep;
            r_offered   <= n_offered;
            r_out_valid <= n_out_valid;
            r_rd_n      <= n_rd_n;
            r_idx       <= n_idx;
            r_rd_nohit  <= n_rd_nohit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank   <= n_rank;
        r_out    <= n_out;
        r_no_hit <= n_no_hit;
        r_last   <= n_last;
    end

    assign o_in_stall   = (r_state == S_READ);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_rank       = r_rank;
    assign o_kept_score = r_out.score;
    assign o_kept_entry = r_out.entry;
    assign o_no_hit     = r_no_hit;
    assign o_last       = r_last;

    a_keep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_keep != '0) && (32'(r_keep) <= SLOTS))
        else $error("keep count out of range");

    a_rd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !r_rd_nohit) |-> (r_rd_n != '0) && (32'(r_idx) < 32'(r_rd_n)))
        else $error("readout index past word count");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_offered == '0))
        else $error("offer count not zero after clear");

    a_nohit_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_hit) |-> (o_last && o_rank == '0 && o_kept_score == '0))
        else $error("malformed no-hit word");

    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !w_load_out) |=> (r_state == S_READ && $stable(r_idx)))
        else $error("readout advanced without loading a word");

endmodule
